FILE: hw/rtl/mssfm_pkg.sv
// shared types, constants and helpers for the motor start and stall fault monitor
`default_nettype none

package mssfm_pkg;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;

	// register indexes on the configuration port
	localparam logic [CFG_ADDR_W-1:0] CFG_START_OVERSPEED = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_STALL_MIN_SPEED = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_STALL_MAX_SPEED = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_STALL_FAST_SPEED = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_RESTART_LIMIT = 3'd4;

	// start fault levels
	localparam logic [1:0] START_NONE = 2'd0;
	localparam logic [1:0] START_OVERSPEED = 2'd1;
	localparam logic [1:0] START_LOW_EMF = 2'd2;
	localparam logic [1:0] START_MODE_TIMEOUT = 2'd3;

	// stall fault levels
	localparam logic [1:0] STALL_NONE = 2'd0;
	localparam logic [1:0] STALL_EMF = 2'd1;
	localparam logic [1:0] STALL_LOW_SPEED = 2'd2;
	localparam logic [1:0] STALL_HIGH_SPEED = 2'd3;

	// timing windows, in ticks
	localparam logic [10:0] START_WINDOW = 11'd1000;
	localparam logic [10:0] EMF_SETTLE = 11'd1500;
	localparam logic [8:0] MODE_TIMEOUT = 9'd400;
	localparam logic [10:0] WIN_MAX = 11'd2047;

	// thresholds
	localparam logic [15:0] START_EMF_MIN = 16'd20;
	localparam logic [15:0] SETTLE_EMF_MIN = 16'd5;
	localparam logic [4:0] LOW_EMF_TRIP = 5'd20;
	localparam logic [15:0] STALL_EMF_MIN = 16'd10;
	localparam logic [15:0] STALL_FAST_EMF_MIN = 16'd40;
	localparam logic [3:0] STALL_EMF_TRIP = 4'd10;
	localparam logic [3:0] STALL_SPEED_TRIP = 4'd8;
	localparam logic [15:0] RESTART_RUN_MS_MAX = 16'd2500;
	localparam logic [15:0] RESTART_DELAY_DEF = 16'd10;

	typedef struct packed {
		logic motor_running;
		logic signed [15:0] speed_filtered;
		logic [15:0] emf_level;
		logic signed [15:0] estimator_speed;
		logic in_startup_mode;
		logic [15:0] run_time_ms;
		logic [7:0] restart_count;
		logic restart_armed_now;
		logic [15:0] restart_delay_now;
	} item_t;

	typedef struct packed {
		logic shutdown;
		logic [1:0] start_fail_level;
		logic [1:0] stall_level;
		logic restart_armed_next;
		logic [15:0] restart_delay_next;
	} result_t;

	typedef struct packed {
		logic signed [15:0] start_overspeed_limit;
		logic signed [15:0] stall_min_speed;
		logic signed [15:0] stall_max_speed;
		logic signed [15:0] stall_fast_speed;
		logic [7:0] restart_limit;
	} cfg_t;

	typedef struct packed {
		logic [10:0] start_speed_window;
		logic [10:0] start_emf_window;
		logic [10:0] emf_settle_delay;
		logic [4:0] low_emf_score;
		logic [8:0] startup_mode_timer;
		logic [10:0] stall_delay;
		logic [3:0] stall_emf_score;
		logic [3:0] stall_speed_score;
	} mon_state_t;

	// saturating increment for the 11-bit window counters
	function automatic logic [10:0] inc11(input logic [10:0] v);
		return (v == WIN_MAX) ? WIN_MAX : v + 11'd1;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mssfm_check.sv
// per-tick start and stall checks: next monitor state and the result beat
`default_nettype none

module mssfm_check (
	input  mssfm_pkg::item_t      item,
	input  mssfm_pkg::cfg_t       cfg,
	input  mssfm_pkg::mon_state_t st,
	output mssfm_pkg::mon_state_t st_next,
	output mssfm_pkg::result_t    result
);
	import mssfm_pkg::*;

	logic [1:0] start_lv;
	logic [1:0] stall_lv;
	logic       fault;
	logic       out_of_band;
	logic       emf_stall;

	assign out_of_band = (item.speed_filtered < cfg.stall_min_speed) ||
		(item.speed_filtered > cfg.stall_max_speed);
	assign emf_stall = (item.emf_level < STALL_EMF_MIN) ||
		((item.estimator_speed > cfg.stall_fast_speed) &&
		(item.emf_level < STALL_FAST_EMF_MIN));

	always_comb begin
		st_next  = st;
		start_lv = START_NONE;
		stall_lv = STALL_NONE;

		if (item.motor_running) begin
			// start check
			if (st.start_speed_window <= START_WINDOW) begin
				st_next.start_speed_window = inc11(st.start_speed_window);
				if ((item.speed_filtered > cfg.start_overspeed_limit) &&
					(item.emf_level < START_EMF_MIN)) begin
					st_next.start_speed_window = '0;
					start_lv = START_OVERSPEED;
				end
			end

			if (st.start_emf_window <= START_WINDOW) begin
				st_next.start_emf_window = inc11(st.start_emf_window);
				st_next.emf_settle_delay = inc11(st.emf_settle_delay);
				if (st_next.emf_settle_delay >= EMF_SETTLE) begin
					st_next.emf_settle_delay = EMF_SETTLE;
					if (item.emf_level < SETTLE_EMF_MIN) begin
						st_next.low_emf_score = st.low_emf_score + 5'd1;
						if (st_next.low_emf_score >= LOW_EMF_TRIP) begin
							st_next.emf_settle_delay = '0;
							st_next.low_emf_score = '0;
							start_lv = START_LOW_EMF;
						end
					end else if (st.low_emf_score != '0) begin
						st_next.low_emf_score = st.low_emf_score - 5'd1;
					end
				end
			end else begin
				st_next.low_emf_score = '0;
			end

			if (item.in_startup_mode) begin
				st_next.startup_mode_timer = st.startup_mode_timer + 9'd1;
				if (st_next.startup_mode_timer >= MODE_TIMEOUT) begin
					st_next.startup_mode_timer = '0;
					start_lv = START_MODE_TIMEOUT;
				end
			end

			// stall check is skipped once a start fault stopped the drive
			if (start_lv == START_NONE) begin
				if (st.stall_delay <= START_WINDOW) begin
					st_next.stall_delay = inc11(st.stall_delay);
				end else begin
					if (emf_stall) begin
						st_next.stall_emf_score = st.stall_emf_score + 4'd1;
						if (st_next.stall_emf_score >= STALL_EMF_TRIP) begin
							st_next.stall_emf_score = '0;
							stall_lv = STALL_EMF;
						end
					end else if (st.stall_emf_score != '0) begin
						st_next.stall_emf_score = st.stall_emf_score - 4'd1;
					end

					// speed fault overrides an emf fault in the same tick
					if (out_of_band) begin
						st_next.stall_speed_score = st.stall_speed_score + 4'd1;
						if (st_next.stall_speed_score >= STALL_SPEED_TRIP) begin
							st_next.stall_speed_score = '0;
							stall_lv = (item.speed_filtered < cfg.stall_min_speed) ?
								STALL_LOW_SPEED : STALL_HIGH_SPEED;
						end
					end else if (st.stall_speed_score != '0) begin
						st_next.stall_speed_score = st.stall_speed_score - 4'd1;
					end
				end
			end
		end
	end

	assign fault = (start_lv != START_NONE) || (stall_lv != STALL_NONE);

	always_comb begin
		result.shutdown           = fault;
		result.start_fail_level   = start_lv;
		result.stall_level        = stall_lv;
		result.restart_armed_next = item.restart_armed_now;
		result.restart_delay_next = item.restart_delay_now;
		if (fault && !item.restart_armed_now) begin
			if ((item.run_time_ms < RESTART_RUN_MS_MAX) &&
				(item.restart_count < cfg.restart_limit)) begin
				result.restart_armed_next = 1'b1;
				if (item.restart_delay_now == '0) begin
					result.restart_delay_next = RESTART_DELAY_DEF;
				end
			end else begin
				result.restart_armed_next = 1'b0;
				result.restart_delay_next = '0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/motor_start_stall_fault_monitor.sv
// motor start and stall fault monitor: top level with state, config and result registers
// each accepted item beat gives its result beat from the result register in the next cycle
// throughput: one item per cycle unless result_ready holds the output; the single result register is the only stage
// a new item is taken whenever the result register is empty or being drained
// reset: all check counters clear to zero, config registers take their defaults,
// and no result is pending
`default_nettype none

module motor_start_stall_fault_monitor (
	input  wire                                      clk,
	input  wire                                      arst_n,
	input  wire                                      item_valid,
	output logic                                     item_ready,
	input  mssfm_pkg::item_t                         item,
	output logic                                     result_valid,
	input  wire                                      result_ready,
	output mssfm_pkg::result_t                       result,
	input  wire                                      cfg_we,
	input  wire  [mssfm_pkg::CFG_ADDR_W-1:0]         cfg_addr,
	input  wire  [mssfm_pkg::CFG_DATA_W-1:0]         cfg_wdata
);
	import mssfm_pkg::*;

	cfg_t       cfg_q;
	mon_state_t state_q;
	mon_state_t state_next;
	result_t    result_comb;
	result_t    result_q;
	logic       result_valid_q;
	logic       item_fire;

	assign item_ready = !result_valid_q || result_ready;
	assign item_fire  = item_valid && item_ready;

	mssfm_check u_check (
		.item    (item),
		.cfg     (cfg_q),
		.st      (state_q),
		.st_next (state_next),
		.result  (result_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_overspeed_limit <= 16'sd30000;
			cfg_q.stall_min_speed       <= 16'sd1000;
			cfg_q.stall_max_speed       <= 16'sd30000;
			cfg_q.stall_fast_speed      <= 16'sd800;
			cfg_q.restart_limit         <= 8'd3;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_START_OVERSPEED:  cfg_q.start_overspeed_limit <= cfg_wdata;
				CFG_STALL_MIN_SPEED:  cfg_q.stall_min_speed <= cfg_wdata;
				CFG_STALL_MAX_SPEED:  cfg_q.stall_max_speed <= cfg_wdata;
				CFG_STALL_FAST_SPEED: cfg_q.stall_fast_speed <= cfg_wdata;
				CFG_RESTART_LIMIT:    cfg_q.restart_limit <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (item_fire) begin
				state_q <= state_next;
			end
			if (item_fire) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (item_fire) begin
			result_q <= result_comb;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire
